[rtl/aobc_pkg.sv]
// ----------------------------------------------------------------------------
// aobc_pkg
// Shared types and constants of the ADC average, offset and gain calibrator.
// ----------------------------------------------------------------------------
package aobc_pkg;

  // field widths
  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 14;
  localparam int VALUE_W    = 20;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  // four channels: voltage 0, current 0, voltage 1, current 1
  localparam int NUM_LANES = 4;

  // pipeline stages behind the accumulators, before the output register
  localparam int NUM_STG = 5;

  // difference times gain
  localparam int P_W = SAMPLE_W + GAIN_W;

  // scale by 256/10000 = 16/625: y = 16*p, value = floor(y * SCALE_M >> SCALE_S)
  // y < 2^30, SCALE_M = ceil(2^40 / 625), error term 349 <= 2^10 keeps it exact
  localparam int SCALE_SH  = 4;
  localparam int SCALE_Y_W = P_W + SCALE_SH;
  localparam int SCALE_M_W = 31;
  localparam int SCALE_S   = 40;
  localparam logic [SCALE_M_W-1:0] SCALE_M = 31'd1759218605;
  localparam int PROD_W    = SCALE_Y_W + SCALE_M_W;

  // value >= 2^20 exactly when p >= 625 * 2^20 / 16
  localparam logic [P_W-1:0] SAT_P = 26'd40960000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // register map
  typedef enum logic [2:0] {
    REG_VOLT0_OFFSET = 3'd0,
    REG_CURR0_OFFSET = 3'd1,
    REG_VOLT1_OFFSET = 3'd2,
    REG_CURR1_OFFSET = 3'd3,
    REG_VOLT0_GAIN   = 3'd4,
    REG_CURR0_GAIN   = 3'd5,
    REG_VOLT1_GAIN   = 3'd6,
    REG_CURR1_GAIN   = 3'd7
  } cfg_reg_t;

  // load enables from the controller to the lanes and the merge stage
  typedef struct packed {
    logic               acc_en;
    logic               last;
    logic [NUM_STG:1]   ld;
    logic               ld_out;
  } ctl_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic [SAMPLE_W-1:0] avg;
    logic                sat;
    logic [VALUE_W-1:0]  quo;
  } lane_res_t;

endpackage

[rtl/aobc_ctrl.sv]
// ----------------------------------------------------------------------------
// aobc_ctrl
// Frame counter and valid/stall chain of the lane pipeline.
// ----------------------------------------------------------------------------
module aobc_ctrl #(
  parameter int FRAMES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output aobc_pkg::ctl_t ctl
);
  import aobc_pkg::*;

  localparam int CNT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [NUM_STG:1]     v_r;
  logic [NUM_STG:1]     v_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [NUM_STG+1:1]   rdy;
  logic                 last;
  logic                 acc;

  // ready ripples back from the output register
  always_comb begin
    rdy[NUM_STG+1] = !out_valid_r || !out_stall;
    for (int k = NUM_STG; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // only a frame-completing item needs room in the first stage
  assign last     = (cnt_r == CNT_W'(FRAMES - 1));
  assign in_stall = last && !rdy[1];
  assign acc      = in_valid && !in_stall;

  // load enables and next valids
  always_comb begin
    ctl.acc_en = acc;
    ctl.last   = last;
    ctl.ld[1]  = acc && last;
    for (int k = 2; k <= NUM_STG; k++) begin
      ctl.ld[k] = v_r[k-1] && rdy[k];
    end
    ctl.ld_out = v_r[NUM_STG] && rdy[NUM_STG+1];
    for (int k = 1; k <= NUM_STG; k++) begin
      v_nxt[k] = ctl.ld[k] || (v_r[k] && !rdy[k+1]);
    end
    out_valid_nxt = ctl.ld_out || (out_valid_r && out_stall);
    cnt_nxt       = cnt_r;
    if (acc) begin
      cnt_nxt = last ? '0 : cnt_r + CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/aobc_lane.sv]
// ----------------------------------------------------------------------------
// aobc_lane
// One channel: accumulator, average by reciprocal multiply, offset and gain.
// ----------------------------------------------------------------------------
module aobc_lane #(
  parameter int FRAMES     = 16,
  parameter bit IS_CURRENT = 1'b0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  aobc_pkg::ctl_t                     ctl,
  input  logic [aobc_pkg::SAMPLE_W-1:0]      sample,
  input  logic [aobc_pkg::SAMPLE_W-1:0]      offset,
  input  logic [aobc_pkg::GAIN_W-1:0]        gain,
  output aobc_pkg::lane_res_t                res
);
  import aobc_pkg::*;

  // sum / FRAMES as floor(sum * DIV_M >> DIV_S), exact for every sum < 2^SUM_W
  localparam int     SUM_W = $clog2(FRAMES * SAMPLE_MAX + 1);
  localparam int     LOG_N = $clog2(FRAMES);
  localparam int     DIV_S = SUM_W + LOG_N;
  localparam int     MW    = DIV_S + 1;
  localparam longint DIV_M = ((longint'(1) << DIV_S) + longint'(FRAMES) - 1)
                             / longint'(FRAMES);
  localparam int     PW    = SUM_W + MW;
  localparam logic [MW-1:0] DIV_M_C = MW'(DIV_M);

  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     sum_nxt;
  logic [SUM_W-1:0]     s1_sum_r;
  logic [PW-1:0]        s2_prod_r;
  logic [SAMPLE_W-1:0]  s3_avg_r;
  logic [SAMPLE_W-1:0]  s3_diff_r;
  logic [SAMPLE_W-1:0]  s4_avg_r;
  logic [P_W-1:0]       s4_p_r;
  logic [SAMPLE_W-1:0]  s5_avg_r;
  logic                 s5_sat_r;
  logic [PROD_W-1:0]    s5_prod_r;
  logic [SAMPLE_W-1:0]  avg;
  logic [SAMPLE_W-1:0]  diff;

  // running sum including this item
  assign sum_nxt = sum_r + SUM_W'(sample);

  // accumulator, cleared on the completing frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.acc_en) begin
      sum_r <= ctl.last ? '0 : sum_nxt;
    end
  end

  // offset difference, clamped at zero; current channels are inverted
  assign avg = s2_prod_r[DIV_S +: SAMPLE_W];
  always_comb begin
    diff = '0;
    if (IS_CURRENT) begin
      if (avg <= offset) begin
        diff = offset - avg;
      end
    end else begin
      if (avg >= offset) begin
        diff = avg - offset;
      end
    end
  end

  // result pipeline
  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      s1_sum_r <= sum_nxt;
    end
    if (ctl.ld[2]) begin
      s2_prod_r <= PW'(s1_sum_r) * PW'(DIV_M_C);
    end
    if (ctl.ld[3]) begin
      s3_avg_r  <= avg;
      s3_diff_r <= diff;
    end
    if (ctl.ld[4]) begin
      s4_avg_r <= s3_avg_r;
      s4_p_r   <= P_W'(s3_diff_r) * P_W'(gain);
    end
    if (ctl.ld[5]) begin
      s5_avg_r  <= s4_avg_r;
      s5_sat_r  <= (s4_p_r >= SAT_P);
      s5_prod_r <= PROD_W'({s4_p_r, SCALE_SH'(0)}) * PROD_W'(SCALE_M);
    end
  end

  assign res.avg = s5_avg_r;
  assign res.sat = s5_sat_r;
  assign res.quo = s5_prod_r[SCALE_S +: VALUE_W];

endmodule

[rtl/aobc_merge.sv]
// ----------------------------------------------------------------------------
// aobc_merge
// Output register: gathers the four lanes and applies value saturation.
// ----------------------------------------------------------------------------
module aobc_merge (
  input  logic                           clk,
  input  logic                           ld_out,
  input  aobc_pkg::lane_res_t            res     [aobc_pkg::NUM_LANES],
  output logic [aobc_pkg::SAMPLE_W-1:0]  avg_out [aobc_pkg::NUM_LANES],
  output logic [aobc_pkg::VALUE_W-1:0]   val_out [aobc_pkg::NUM_LANES]
);
  import aobc_pkg::*;

  logic [SAMPLE_W-1:0] avg_r [NUM_LANES];
  logic [VALUE_W-1:0]  val_r [NUM_LANES];

  // load all lanes at once when the result moves out
  always_ff @(posedge clk) begin
    if (ld_out) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        avg_r[i] <= res[i].avg;
        val_r[i] <= res[i].sat ? VALUE_MAX : res[i].quo;
      end
    end
  end

  assign avg_out = avg_r;
  assign val_out = val_r;

endmodule

[rtl/adc_average_offset_gain_calibrator_top.sv]
// ----------------------------------------------------------------------------
// adc_average_offset_gain_calibrator_top
// Block averager of four ADC channels with offset and gain calibration.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid / in_stall    | four 12-bit samples of one scan frame
//  out     | out_valid / out_stall  | four averages, four calibrated values
//  cfg     | cfg_valid / cfg_ready  | cfg_index (3 bit), cfg_data (14 bit)
//
//  one frame is accepted per cycle while in_stall is low; every
//  FRAMES_PER_AVERAGE-th frame yields a result through five lane stages plus
//  the output register; the lane stages do the divide, offset, gain and scale.
//  reset clears sums, frame count, pipeline valids and the offset and gain registers.
//  in_stall rises only for a frame-completing item while the pipe is full
//  behind a stalled output; cfg_ready is always high.
// ----------------------------------------------------------------------------
module adc_average_offset_gain_calibrator_top #(
  parameter int FRAMES_PER_AVERAGE = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aobc_pkg::SAMPLE_W-1:0] in_volt0_sample,
  input  logic [aobc_pkg::SAMPLE_W-1:0] in_curr0_sample,
  input  logic [aobc_pkg::SAMPLE_W-1:0] in_volt1_sample,
  input  logic [aobc_pkg::SAMPLE_W-1:0] in_curr1_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [aobc_pkg::SAMPLE_W-1:0] out_volt0_average,
  output logic [aobc_pkg::SAMPLE_W-1:0] out_curr0_average,
  output logic [aobc_pkg::SAMPLE_W-1:0] out_volt1_average,
  output logic [aobc_pkg::SAMPLE_W-1:0] out_curr1_average,
  output logic [aobc_pkg::VALUE_W-1:0]  out_volt0_value,
  output logic [aobc_pkg::VALUE_W-1:0]  out_curr0_value,
  output logic [aobc_pkg::VALUE_W-1:0]  out_volt1_value,
  output logic [aobc_pkg::VALUE_W-1:0]  out_curr1_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [aobc_pkg::GAIN_W-1:0]   cfg_data
);
  import aobc_pkg::*;

  ctl_t                ctl;
  logic [SAMPLE_W-1:0] offset_r [NUM_LANES];
  logic [GAIN_W-1:0]   gain_r   [NUM_LANES];
  logic [SAMPLE_W-1:0] samples  [NUM_LANES];
  lane_res_t           res      [NUM_LANES];
  logic [SAMPLE_W-1:0] avg_out  [NUM_LANES];
  logic [VALUE_W-1:0]  val_out  [NUM_LANES];

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        offset_r[i] <= '0;
        gain_r[i]   <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VOLT0_OFFSET: offset_r[0] <= cfg_data[SAMPLE_W-1:0];
        REG_CURR0_OFFSET: offset_r[1] <= cfg_data[SAMPLE_W-1:0];
        REG_VOLT1_OFFSET: offset_r[2] <= cfg_data[SAMPLE_W-1:0];
        REG_CURR1_OFFSET: offset_r[3] <= cfg_data[SAMPLE_W-1:0];
        REG_VOLT0_GAIN:   gain_r[0]   <= cfg_data;
        REG_CURR0_GAIN:   gain_r[1]   <= cfg_data;
        REG_VOLT1_GAIN:   gain_r[2]   <= cfg_data;
        REG_CURR1_GAIN:   gain_r[3]   <= cfg_data;
      endcase
    end
  end

  // control
  aobc_ctrl #(
    .FRAMES (FRAMES_PER_AVERAGE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // lanes, in channel order
  assign samples[0] = in_volt0_sample;
  assign samples[1] = in_curr0_sample;
  assign samples[2] = in_volt1_sample;
  assign samples[3] = in_curr1_sample;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    aobc_lane #(
      .FRAMES     (FRAMES_PER_AVERAGE),
      .IS_CURRENT (1'(i % 2))
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sample (samples[i]),
      .offset (offset_r[i]),
      .gain   (gain_r[i]),
      .res    (res[i])
    );
  end

  // output register
  aobc_merge u_merge (
    .clk     (clk),
    .ld_out  (ctl.ld_out),
    .res     (res),
    .avg_out (avg_out),
    .val_out (val_out)
  );

  assign out_volt0_average = avg_out[0];
  assign out_curr0_average = avg_out[1];
  assign out_volt1_average = avg_out[2];
  assign out_curr1_average = avg_out[3];
  assign out_volt0_value   = val_out[0];
  assign out_curr0_value   = val_out[1];
  assign out_volt1_value   = val_out[2];
  assign out_curr1_value   = val_out[3];

endmodule

[rtl/aobc_checker.sv]
// ----------------------------------------------------------------------------
// aobc_checker
// Port-level checks of the calibrator, bound to the top level.
// ----------------------------------------------------------------------------
module aobc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [aobc_pkg::VALUE_W-1:0]  out_volt0_value,
  input logic [aobc_pkg::SAMPLE_W-1:0] out_curr0_average
);

  // a stalled result stays and keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_volt0_value)
      && $stable(out_curr0_average))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // input backs up only when a result is held by the consumer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // a result moved out frees the pipe, so the input is not stalled next cycle unless a new result is waiting
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && in_valid |=> !in_stall || out_valid)
    else $error("input stalled after pipe drained");

endmodule

bind adc_average_offset_gain_calibrator_top aobc_checker u_aobc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_volt0_value   (out_volt0_value),
  .out_curr0_average (out_curr0_average)
);

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-channel ADC block averager. Scan frames go
// in with random gaps while the output side stalls at random; a scoreboard
// keeps its own running sums and calibration registers, predicts each result
// item and compares it field by field, in order, with what the block emits.
// ----------------------------------------------------------------------------
module tb;
  import aobc_pkg::*;

  localparam int FRAMES      = 16;
  localparam int GAIN_DIV    = 10000;
  localparam int GAIN_MAX    = (1 << GAIN_W) - 1;
  localparam int MAX_REPORTS = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_WAIT = 8;
  localparam int MIN_ITEMS   = 450;

  // lane order: voltage 0, current 0, voltage 1, current 1
  typedef logic [NUM_LANES-1:0][SAMPLE_W-1:0] frame_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] avg;
    logic [NUM_LANES-1:0][VALUE_W-1:0]  value;
  } calib_t;

  // running sums, calibration registers and the queue of pending averages
  class calib_scoreboard;
    logic [SAMPLE_W-1:0] offset [NUM_LANES];
    logic [GAIN_W-1:0]   gain [NUM_LANES];
    logic [15:0]         sums [NUM_LANES];
    int unsigned         frame_cnt;
    calib_t              averages_q [$];
    int unsigned         failures;
    int unsigned         results_done;
    string               lane_name [NUM_LANES];

    function new();
      lane_name = '{"volt0", "curr0", "volt1", "curr1"};
      for (int i = 0; i < NUM_LANES; i++) begin
        offset[i] = '0;
        gain[i]   = '0;
        sums[i]   = '0;
      end
      frame_cnt    = 0;
      failures     = 0;
      results_done = 0;
    endfunction

    // offsets keep only their low twelve bits
    function void write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] data);
      if (idx < REG_VOLT0_GAIN) offset[idx] = data[SAMPLE_W-1:0];
      else gain[idx - REG_VOLT0_GAIN] = data;
    endfunction

    function void note_frame(frame_t f);
      calib_t              r;
      logic [SAMPLE_W-1:0] diff;
      longint unsigned     scaled;
      for (int i = 0; i < NUM_LANES; i++) sums[i] += 16'(f[i]);
      frame_cnt++;
      if (frame_cnt < FRAMES) return;
      for (int i = 0; i < NUM_LANES; i++) begin
        r.avg[i] = SAMPLE_W'(sums[i] / FRAMES);
        diff = '0;
        // voltages count up from the offset, currents count down to it
        if (i % 2 == 0) begin
          if (r.avg[i] >= offset[i]) diff = r.avg[i] - offset[i];
        end else if (r.avg[i] <= offset[i]) begin
          diff = offset[i] - r.avg[i];
        end
        // gain over 10000 with 8 fraction bits, clipped at full scale
        scaled = 64'(diff);
        scaled = scaled * gain[i] * 256 / GAIN_DIV;
        if (scaled > VALUE_MAX) r.value[i] = VALUE_MAX;
        else r.value[i] = scaled[VALUE_W-1:0];
        sums[i] = '0;
      end
      frame_cnt = 0;
      averages_q.push_back(r);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_result(calib_t got);
      calib_t want;
      if (averages_q.size() == 0) begin
        report("result item with nothing pending");
        return;
      end
      want = averages_q.pop_front();
      results_done++;
      for (int i = 0; i < NUM_LANES; i++) begin
        if (got.avg[i] !== want.avg[i])
          report($sformatf("result %0d %s_average: expected %0d, got %0d",
                           results_done, lane_name[i], want.avg[i], got.avg[i]));
        if (got.value[i] !== want.value[i])
          report($sformatf("result %0d %s_value: expected %0d, got %0d",
                           results_done, lane_name[i], want.value[i], got.value[i]));
      end
    endfunction

    function int pending();
      return averages_q.size();
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  frame_t                              in_frame;
  logic                                out_valid;
  logic                                out_stall;
  wire [NUM_LANES-1:0][SAMPLE_W-1:0]   out_avg;
  wire [NUM_LANES-1:0][VALUE_W-1:0]    out_value;
  logic                                cfg_valid;
  logic                                cfg_ready;
  cfg_reg_t                            cfg_index;
  logic [GAIN_W-1:0]                   cfg_data;
  calib_scoreboard                     sb;
  int unsigned                         cycles = 0;

  adc_average_offset_gain_calibrator_top #(
    .FRAMES_PER_AVERAGE (FRAMES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_volt0_sample   (in_frame[0]),
    .in_curr0_sample   (in_frame[1]),
    .in_volt1_sample   (in_frame[2]),
    .in_curr1_sample   (in_frame[3]),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_volt0_average (out_avg[0]),
    .out_curr0_average (out_avg[1]),
    .out_volt1_average (out_avg[2]),
    .out_curr1_average (out_avg[3]),
    .out_volt0_value   (out_value[0]),
    .out_curr0_value   (out_value[1]),
    .out_volt1_value   (out_value[2]),
    .out_curr1_value   (out_value[3]),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // both channels sampled at the edge that moves an item
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_frame(in_frame);
      if (out_valid && !out_stall) sb.check_result({out_avg, out_value});
    end
  end

  // output back-pressure, with long stall-free stretches now and then
  initial begin
    int len;
    forever begin
      len = pick_gap();
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(40, 120);
      else len = $urandom_range(1, 6);
      repeat (len) @(posedge clk);
    end
  end

  // cfg_valid is left high for back-to-back writes, the caller drops it
  task automatic write_cfg(cfg_reg_t idx, logic [GAIN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // in_valid stays high into the next item unless a gap is taken
  task automatic send_frame(frame_t f, bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame <= f;
    do @(posedge clk); while (in_stall);
  endtask

  // wait out every pending result, then let the pipeline settle
  task automatic drain();
    do @(negedge clk); while (sb.pending() != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  initial begin
    frame_t            f;
    cfg_reg_t          idx;
    logic [GAIN_W-1:0] data;
    int                lane_center [NUM_LANES];
    int                lane_spread [NUM_LANES];
    int                rand_items;
    int                n_frames;
    int                kind;
    int                s;
    bit                no_gaps;

    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_frame  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_VOLT0_OFFSET;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // junk above the offset width, full-scale gain, gain past full scale
    write_cfg(REG_VOLT0_OFFSET, 14'h3000);
    write_cfg(REG_CURR0_OFFSET, 14'h3FFF);
    write_cfg(REG_VOLT1_OFFSET, 14'h0800);
    write_cfg(REG_CURR1_OFFSET, 14'h0FFF);
    write_cfg(REG_VOLT0_GAIN, GAIN_W'(GAIN_DIV));
    write_cfg(REG_CURR0_GAIN, GAIN_W'(GAIN_MAX));
    write_cfg(REG_VOLT1_GAIN, GAIN_W'(GAIN_MAX));
    write_cfg(REG_CURR1_GAIN, '0);
    cfg_valid <= 1'b0;

    // one full block: top code, zero code, toggling codes and patterns
    for (int k = 0; k < FRAMES; k++) begin
      f[0] = '1;
      f[1] = '0;
      f[2] = {SAMPLE_W{k[0]}};
      if (k[0]) f[3] = 12'hAAA;
      else f[3] = 12'h555;
      send_frame(f, k < FRAMES / 2);
    end
    in_valid <= 1'b0;
    drain();

    // random phases: new settings, then frames shaped around them
    rand_items = 0;
    for (int ph = 0; rand_items < MIN_ITEMS; ph++) begin
      for (int r = 0; r < 2 * NUM_LANES; r++) begin
        idx = cfg_reg_t'(r);
        if (ph == 0 || $urandom_range(0, 1) == 1) begin
          kind = $urandom_range(0, 4);
          if (idx < REG_VOLT0_GAIN) begin
            if (kind == 0) data = '0;
            else if (kind == 1) data = GAIN_W'(SAMPLE_MAX);
            else data = GAIN_W'($urandom_range(0, SAMPLE_MAX));
            // stray upper bits must be dropped
            data[GAIN_W-1:SAMPLE_W] = (GAIN_W-SAMPLE_W)'($urandom_range(0, 3));
          end else begin
            if (kind == 0) data = '0;
            else if (kind == 1) data = GAIN_W'(GAIN_DIV);
            else if (kind == 2) data = GAIN_W'(GAIN_MAX);
            else if (kind == 3) data = GAIN_W'($urandom_range(0, GAIN_MAX));
            else data = GAIN_W'($urandom_range(0, GAIN_DIV));
          end
          write_cfg(idx, data);
        end
      end
      cfg_valid <= 1'b0;

      // per lane: sit on the offset, a random level or a rail
      for (int i = 0; i < NUM_LANES; i++) begin
        case ($urandom_range(0, 2))
          0:       lane_center[i] = int'(sb.offset[i]);
          1:       lane_center[i] = $urandom_range(0, SAMPLE_MAX);
          default: lane_center[i] = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0;
        endcase
        case ($urandom_range(0, 3))
          0:       lane_spread[i] = 0;
          1:       lane_spread[i] = $urandom_range(1, 16);
          2:       lane_spread[i] = $urandom_range(64, 512);
          default: lane_spread[i] = -1;
        endcase
      end

      // mostly whole blocks, sometimes a partial one carried over
      if ($urandom_range(0, 3) == 0) n_frames = $urandom_range(1, 2 * FRAMES);
      else n_frames = FRAMES;
      no_gaps = ($urandom_range(0, 3) == 0);

      for (int k = 0; k < n_frames; k++) begin
        for (int i = 0; i < NUM_LANES; i++) begin
          if (lane_spread[i] < 0) begin
            s = $urandom_range(0, SAMPLE_MAX);
          end else begin
            s = lane_center[i] - lane_spread[i] + int'($urandom_range(0, 2 * lane_spread[i]));
          end
          if (s < 0) s = 0;
          if (s > SAMPLE_MAX) s = SAMPLE_MAX;
          f[i] = s[SAMPLE_W-1:0];
        end
        send_frame(f, no_gaps);
        rand_items++;
      end
      in_valid <= 1'b0;
      drain();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
